@@ rtl/fvg_pkg.sv @@
`default_nettype none
package fvg_pkg;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FAT12 = 2'd1,
    ST_EXFAT = 2'd2
  } status_t;

  localparam logic KIND_FAT16 = 1'b0;
  localparam logic KIND_FAT32 = 1'b1;

  localparam logic [31:0] MIN_FAT16_CLUSTERS = 32'd4085;
  localparam logic [31:0] MIN_FAT32_CLUSTERS = 32'd65525;
  localparam logic [31:0] MAX_FAT32_CLUSTERS = 32'd268435445;
  localparam logic [31:0] FIRST_DATA_CLUSTER = 32'd2;

  localparam int IN_DATA_W   = 224;
  localparam int OUT_DATA_W  = 200;
  localparam int OUT_USER_W  = 3;
  localparam int ROOT_SECS_W = 22;

  // BIOS parameter block fields of one request
  typedef struct packed {
    logic [31:0] volume_lba;
    logic [15:0] bytes_per_sector;
    logic [7:0]  sectors_per_cluster;
    logic [15:0] reserved_sectors;
    logic [7:0]  fat_copies;
    logic [15:0] root_entries;
    logic [15:0] total_sectors_short;
    logic [15:0] fat_size_short;
    logic [31:0] total_sectors_long;
    logic [31:0] fat_size_long;
    logic [31:0] root_cluster_in;
  } bpb_t;

  // decoded values handed from the decode stage to the layout stage
  typedef struct packed {
    logic [3:0]             sector_size_log;
    logic [2:0]             cluster_size_log;
    logic [31:0]            fat_sectors;
    logic [31:0]            fats_total;
    logic [ROOT_SECS_W-1:0] root_secs;
    logic [31:0]            total_sectors;
    logic [31:0]            first_fat_sector;
    logic [15:0]            reserved_sectors;
    logic [31:0]            root_cluster_in;
  } dec_t;

  typedef struct packed {
    status_t     status;
    logic        fat_kind;
    logic [3:0]  sector_size_log;
    logic [2:0]  cluster_size_log;
    logic [31:0] cluster_count;
    logic [31:0] fat_sectors;
    logic [31:0] first_fat_sector;
    logic [31:0] root_start_sector;
    logic [31:0] data_start_sector;
    logic [31:0] root_cluster;
  } geom_t;

  // index of the highest set bit, zero gives zero
  function automatic logic [3:0] top_bit16(input logic [15:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 1; i < 16; i++) begin
      if (v[i]) begin
        n = 4'(i);
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

@@ rtl/fvg_decode.sv @@
`default_nettype none
module fvg_decode (
  input  fvg_pkg::bpb_t bpb,
  output fvg_pkg::dec_t dec
);
  import fvg_pkg::*;

  logic [3:0]             slog;
  logic [3:0]             clog_full;
  logic [31:0]            fat_sz;
  logic [39:0]            fats_prod;
  logic [15:0]            bps_m1;
  logic [ROOT_SECS_W-1:0] root_bytes;

  always_comb begin
    slog      = top_bit16(bpb.bytes_per_sector);
    clog_full = top_bit16({8'd0, bpb.sectors_per_cluster});
    fat_sz    = (bpb.fat_size_short != 16'd0) ? {16'd0, bpb.fat_size_short}
                                              : bpb.fat_size_long;
    fats_prod = fat_sz * {32'd0, bpb.fat_copies};
    // zero sector size: decrement saturates at zero
    bps_m1    = (bpb.bytes_per_sector != 16'd0) ? bpb.bytes_per_sector - 16'd1 : 16'd0;
    root_bytes = {1'b0, bpb.root_entries, 5'd0} + {6'd0, bps_m1};

    dec.sector_size_log  = slog;
    dec.cluster_size_log = clog_full[2:0];
    dec.fat_sectors      = fat_sz;
    dec.fats_total       = fats_prod[31:0];
    dec.root_secs        = root_bytes >> slog;
    dec.total_sectors    = (bpb.total_sectors_short != 16'd0)
                           ? {16'd0, bpb.total_sectors_short} : bpb.total_sectors_long;
    dec.first_fat_sector = bpb.volume_lba + {16'd0, bpb.reserved_sectors};
    dec.reserved_sectors = bpb.reserved_sectors;
    dec.root_cluster_in  = bpb.root_cluster_in;
  end

endmodule
`default_nettype wire

@@ rtl/fvg_layout.sv @@
`default_nettype none
module fvg_layout (
  input  fvg_pkg::dec_t  dec,
  output fvg_pkg::geom_t geom
);
  import fvg_pkg::*;

  logic [31:0] root_secs;
  logic [31:0] used_secs;
  logic [31:0] data_secs;
  logic [31:0] clusters;
  logic [31:0] fat_end;
  logic [31:0] data_start;
  logic [31:0] root_offs;

  always_comb begin
    root_secs  = {{(32-ROOT_SECS_W){1'b0}}, dec.root_secs};
    used_secs  = {16'd0, dec.reserved_sectors} + dec.fats_total + root_secs;
    data_secs  = dec.total_sectors - used_secs;
    clusters   = data_secs >> dec.cluster_size_log;
    fat_end    = dec.first_fat_sector + dec.fats_total;
    data_start = fat_end + root_secs;
    // a root cluster below two wraps
    root_offs  = (dec.root_cluster_in - FIRST_DATA_CLUSTER) << dec.cluster_size_log;

    geom.sector_size_log   = dec.sector_size_log;
    geom.cluster_size_log  = dec.cluster_size_log;
    geom.cluster_count     = clusters;
    geom.fat_sectors       = dec.fat_sectors;
    geom.first_fat_sector  = dec.first_fat_sector;
    geom.status            = ST_OK;
    geom.fat_kind          = KIND_FAT16;
    geom.root_start_sector = '0;
    geom.data_start_sector = '0;
    geom.root_cluster      = '0;

    if (clusters < MIN_FAT16_CLUSTERS) begin
      geom.status = ST_FAT12;
    end else if (clusters >= MAX_FAT32_CLUSTERS) begin
      geom.status = ST_EXFAT;
    end else begin
      geom.data_start_sector = data_start;
      if (clusters < MIN_FAT32_CLUSTERS) begin
        geom.root_start_sector = fat_end;
        geom.root_cluster      = FIRST_DATA_CLUSTER;
      end else begin
        geom.fat_kind          = KIND_FAT32;
        geom.root_start_sector = root_offs + data_start;
        geom.root_cluster      = dec.root_cluster_in;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/fat_volume_geometry.sv @@
// FAT volume geometry decoder.
// Slave channel (in_*): one request carries the BIOS parameter block fields of a
// boot sector plus the partition start sector, packed in in_tdata.
// Master channel (out_*): one result per request with the volume layout in
// out_tdata, and status / FAT kind in out_tuser.
// Pipeline: input register, decode stage register, result register. The 32x8
// FAT size multiply sits in the decode stage; the subtract, shift,
// classification compares and sector sums sit in the layout stage.
// A request accepted into the input register passes the decode stage register
// and the result register before it is offered on out_tvalid.
// Throughput: one request per cycle while out_tready stays high; each register stage moves on when it is
// empty or the stage after it moves.
// Stall: while out_tready is low the result holds and the two stages behind
// it still fill, so in_tready drops only once all three stages hold requests.
// Reset (rst_n low, synchronous): all stages empty, out_tvalid low.
`default_nettype none
module fat_volume_geometry (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // volume_lba, bytes_per_sector, sectors_per_cluster, reserved_sectors,
  // fat_copies, root_entries, total_sectors_short, fat_size_short,
  // total_sectors_long, fat_size_long, root_cluster_in
  input  wire logic [fvg_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // sector_size_log, cluster_size_log, cluster_count, fat_sectors,
  // first_fat_sector, root_start_sector, data_start_sector, root_cluster, pad
  output logic [fvg_pkg::OUT_DATA_W-1:0]      out_tdata,
  // status, fat_kind
  output logic [fvg_pkg::OUT_USER_W-1:0]      out_tuser
);
  import fvg_pkg::*;

  logic  in_valid_r;
  bpb_t  in_r;
  logic  dec_valid_r;
  dec_t  dec_r;
  logic  out_valid_r;
  geom_t out_r;

  bpb_t  bpb_nxt;
  dec_t  dec_nxt;
  geom_t out_nxt;

  logic  out_en;
  logic  dec_en;
  logic  in_en;

  assign out_en    = !out_valid_r || out_tready;
  assign dec_en    = !dec_valid_r || out_en;
  assign in_en     = !in_valid_r || dec_en;
  assign in_tready = in_en;

  always_comb begin
    bpb_nxt.volume_lba          = in_tdata[31:0];
    bpb_nxt.bytes_per_sector    = in_tdata[47:32];
    bpb_nxt.sectors_per_cluster = in_tdata[55:48];
    bpb_nxt.reserved_sectors    = in_tdata[71:56];
    bpb_nxt.fat_copies          = in_tdata[79:72];
    bpb_nxt.root_entries        = in_tdata[95:80];
    bpb_nxt.total_sectors_short = in_tdata[111:96];
    bpb_nxt.fat_size_short      = in_tdata[127:112];
    bpb_nxt.total_sectors_long  = in_tdata[159:128];
    bpb_nxt.fat_size_long       = in_tdata[191:160];
    bpb_nxt.root_cluster_in     = in_tdata[223:192];
  end

  fvg_decode u_decode (
    .bpb (in_r),
    .dec (dec_nxt)
  );

  fvg_layout u_layout (
    .dec  (dec_r),
    .geom (out_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      dec_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_en) begin
        in_valid_r <= in_tvalid;
      end
      if (dec_en) begin
        dec_valid_r <= in_valid_r;
      end
      if (out_en) begin
        out_valid_r <= dec_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_en && in_tvalid) begin
      in_r <= bpb_nxt;
    end
    if (dec_en && in_valid_r) begin
      dec_r <= dec_nxt;
    end
    if (out_en && dec_valid_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0,
                       out_r.root_cluster,
                       out_r.data_start_sector,
                       out_r.root_start_sector,
                       out_r.first_fat_sector,
                       out_r.fat_sectors,
                       out_r.cluster_count,
                       out_r.cluster_size_log,
                       out_r.sector_size_log};
  assign out_tuser  = {out_r.fat_kind, out_r.status};

endmodule
`default_nettype wire

@@ rtl/fvg_checker.sv @@
`default_nettype none
module fvg_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [fvg_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic [fvg_pkg::OUT_USER_W-1:0] out_tuser
);
  import fvg_pkg::*;

  logic [31:0] chk_clusters;
  logic [31:0] chk_root_start;
  logic [31:0] chk_data_start;
  logic [31:0] chk_root_cl;

  assign chk_clusters   = out_tdata[38:7];
  assign chk_root_start = out_tdata[134:103];
  assign chk_data_start = out_tdata[166:135];
  assign chk_root_cl    = out_tdata[198:167];

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // supported volumes: cluster count inside the FAT16/FAT32 window, kind by count
  a_class_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == ST_OK |->
      chk_clusters >= MIN_FAT16_CLUSTERS && chk_clusters < MAX_FAT32_CLUSTERS &&
      out_tuser[2] == (chk_clusters >= MIN_FAT32_CLUSTERS) && !out_tdata[199])
    else $error("status ok does not match cluster count");

  a_class_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] != ST_OK |->
      (out_tuser[1:0] == ST_FAT12 && chk_clusters < MIN_FAT16_CLUSTERS ||
       out_tuser[1:0] == ST_EXFAT && chk_clusters >= MAX_FAT32_CLUSTERS) &&
      !out_tuser[2] && chk_root_start == 32'd0 && chk_data_start == 32'd0 &&
      chk_root_cl == 32'd0)
    else $error("unsupported result not cleared or misclassified");

  a_fat16_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == ST_OK && !out_tuser[2] |->
      chk_root_cl == FIRST_DATA_CLUSTER)
    else $error("FAT16 root cluster not two");

endmodule

bind fat_volume_geometry fvg_checker u_fvg_checker (.*);
`default_nettype wire
